FILE: rtl/pli_pkg.sv
// Package for the positional list insert/delete core.
// Holds the default capacity, the operation codes and the status codes.
// No dependencies.
package pli_pkg;

  localparam int CAPACITY = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

FILE: rtl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come from parameters.
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/positional_list_insert_delete_core.sv
// Top level of the positional list insert/delete core.
// Uses pli_pkg (capacity, codes) and pli_ram (list storage).
//
//   channel   direction  handshake              payload
//   request   in         start & !busy          mode, position, item_value
//   result    out        strobe, one cycle      status, list_size, entry_position,
//                                               entry_value, has_entry, last
//
// Sequence: a request is accepted in S_IDLE; where entries must move, the shift then
// moves one entry per cycle and ends by draining the RAM read, S_PUT writes an inserted
// value, and S_DUMP reads the list out through the RAM read port (S_EMPTY if empty).
// The shift and the read-out both go through the single RAM read/write port pair.
// Reset clears the entry count and the sequencer; list contents are not cleared.
// busy is high from the cycle after acceptance until the last result has been shown.
// The receiver cannot stall; each result is valid for the single cycle strobe is high.
module positional_list_insert_delete_core #(
  parameter int CAPACITY = pli_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [$clog2(CAPACITY+1)-1:0]       position,
  input  logic signed [31:0]                  item_value,
  output logic                                strobe,
  output logic [1:0]                          status,
  output logic [$clog2(CAPACITY+1)-1:0]       list_size,
  output logic [$clog2(CAPACITY)-1:0]         entry_position,
  output logic signed [31:0]                  entry_value,
  output logic                                has_entry,
  output logic                                last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_PUT   = 5'b00100,
    S_DUMP  = 5'b01000,
    S_EMPTY = 5'b10000
  } state_t;

  state_t           state;
  logic [CW-1:0]    count;
  logic             op_ins;
  logic [AW-1:0]    op_pos;
  logic [31:0]      op_val;
  pli_pkg::status_t op_status;
  logic [CW-1:0]    left;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    prev_addr;
  logic             rd_valid;
  logic [CW-1:0]    rd_idx;
  logic             pend;
  logic [AW-1:0]    pend_idx;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;
  logic             pend_last;
  logic             accept;
  logic             is_ins;

  assign accept    = start && (state == S_IDLE);
  assign is_ins    = (mode == pli_pkg::MODE_INSERT);
  assign pend_last = ((CW'(pend_idx) + CW'(1)) == count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op_ins ? (prev_addr + AW'(1)) : (prev_addr - AW'(1));
    ram_wdata = ram_rdata;
    ram_raddr = rd_addr;
    case (state)
      S_SHIFT: begin
        ram_we = rd_valid;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = op_pos;
        ram_wdata = op_val;
      end
      S_DUMP: begin
        ram_raddr = rd_idx[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pli_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
      pend     <= 1'b0;
      rd_idx   <= '0;
    end else begin
      if (state != S_DUMP) begin
        rd_idx <= '0;
        pend   <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_valid <= 1'b0;
          if (accept) begin
            op_ins <= is_ins;
            op_pos <= position[AW-1:0];
            op_val <= item_value;
            if (is_ins) begin
              if (position > count) begin
                op_status <= pli_pkg::ST_RANGE;
                state     <= (count == '0) ? S_EMPTY : S_DUMP;
              end else if (count == CW'(CAPACITY)) begin
                op_status <= pli_pkg::ST_FULL;
                state     <= S_DUMP;
              end else begin
                op_status <= pli_pkg::ST_DONE;
                count     <= count + CW'(1);
                left      <= count - position;
                rd_addr   <= AW'(count - CW'(1));
                state     <= (position == count) ? S_PUT : S_SHIFT;
              end
            end else begin
              if (position >= count) begin
                op_status <= pli_pkg::ST_RANGE;
                state     <= (count == '0) ? S_EMPTY : S_DUMP;
              end else begin
                op_status <= pli_pkg::ST_DONE;
                count     <= count - CW'(1);
                left      <= count - CW'(1) - position;
                rd_addr   <= AW'(position + CW'(1));
                if ((count - CW'(1)) == position) begin
                  state <= (count == CW'(1)) ? S_EMPTY : S_DUMP;
                end else begin
                  state <= S_SHIFT;
                end
              end
            end
          end
        end
        S_SHIFT: begin
          if (left != '0) begin
            left      <= left - CW'(1);
            rd_addr   <= op_ins ? (rd_addr - AW'(1)) : (rd_addr + AW'(1));
            prev_addr <= rd_addr;
            rd_valid  <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
            state    <= op_ins ? S_PUT : S_DUMP;
          end
        end
        S_PUT: begin
          state <= S_DUMP;
        end
        S_DUMP: begin
          if (rd_idx < count) begin
            rd_idx   <= rd_idx + CW'(1);
            pend_idx <= rd_idx[AW-1:0];
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && pend_last) begin
            state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state != S_IDLE);
  assign strobe         = ((state == S_DUMP) && pend) || (state == S_EMPTY);
  assign status         = op_status;
  assign list_size      = count;
  assign has_entry      = (state == S_DUMP);
  assign entry_position = (state == S_DUMP) ? pend_idx : '0;
  assign entry_value    = (state == S_DUMP) ? ram_rdata : '0;
  assign last           = (state == S_EMPTY) || (pend && pend_last);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for positional_list_insert_delete_core.
// Keeps a shadow copy of the list, predicts every result of each request and
// checks the strobed results in order. Depends on pli_pkg and the core RTL.
module tb_top;

  localparam int CAP = pli_pkg::CAPACITY;
  localparam int PW = $clog2(CAP + 1);
  localparam int EW = $clog2(CAP);
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * CAP + 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [1:0]         status;
    logic [PW-1:0]      size;
    logic [EW-1:0]      pos;
    logic signed [31:0] value;
    logic               has;
    logic               last;
  } list_view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 mode = pli_pkg::MODE_INSERT;
  logic [PW-1:0]        position = '0;
  logic signed [31:0]   item_value = '0;
  logic                 strobe;
  logic [1:0]           status;
  logic [PW-1:0]        list_size;
  logic [EW-1:0]        entry_position;
  logic signed [31:0]   entry_value;
  logic                 has_entry;
  logic                 last;

  list_view_t           pending_views[$];
  logic signed [31:0]   shadow_list[CAP];
  int                   shadow_len = 0;
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   burst_left = 0;

  positional_list_insert_delete_core #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .position(position),
    .item_value(item_value),
    .strobe(strobe),
    .status(status),
    .list_size(list_size),
    .entry_position(entry_position),
    .entry_value(entry_value),
    .has_entry(has_entry),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL positional_list_insert_delete_core");
      $finish;
    end
  end

  task automatic apply_to_shadow(input logic m, input logic [PW-1:0] p,
                                 input logic signed [31:0] v);
    pli_pkg::status_t st;
    list_view_t       view;
    int               i;
    st = pli_pkg::ST_DONE;
    if (m == pli_pkg::MODE_INSERT) begin
      if (p > shadow_len) begin
        st = pli_pkg::ST_RANGE;
      end else if (shadow_len >= CAP) begin
        st = pli_pkg::ST_FULL;
      end else begin
        for (i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[p[EW-1:0]] = v;
        shadow_len++;
      end
    end else begin
      if (p >= shadow_len) begin
        st = pli_pkg::ST_RANGE;
      end else begin
        for (i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
        shadow_len--;
      end
    end
    view.status = st;
    view.size = PW'(shadow_len);
    if (shadow_len == 0) begin
      view.pos = '0;
      view.value = '0;
      view.has = 1'b0;
      view.last = 1'b1;
      pending_views.push_back(view);
    end else begin
      for (i = 0; i < shadow_len; i++) begin
        view.pos = EW'(i);
        view.value = shadow_list[i];
        view.has = 1'b1;
        view.last = (i + 1 == shadow_len);
        pending_views.push_back(view);
      end
    end
  endtask

  always @(posedge clk) begin
    list_view_t want;
    if (!rst && strobe) begin
      if (pending_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: status=%0d size=%0d pos=%0d value=%0d has=%0b last=%0b",
                   status, list_size, entry_position, entry_value, has_entry, last);
      end else begin
        want = pending_views.pop_front();
        if (status !== want.status || list_size !== want.size ||
            entry_position !== want.pos || entry_value !== want.value ||
            has_entry !== want.has || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch exp: status=%0d size=%0d pos=%0d value=%0d has=%0b last=%0b",
                     want.status, want.size, want.pos, want.value, want.has, want.last);
            $display("         got: status=%0d size=%0d pos=%0d value=%0d has=%0b last=%0b",
                     status, list_size, entry_position, entry_value, has_entry, last);
          end
        end
      end
    end
  end

  task automatic send_request(input logic m, input int p, input logic signed [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    mode <= m;
    position <= p[PW-1:0];
    item_value <= v;
    start <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    apply_to_shadow(m, p[PW-1:0], v);
  endtask

  function automatic logic signed [31:0] pick_value(input int sel);
    case (sel % 7)
      0: pick_value = 32'sh8000_0000;
      1: pick_value = 32'sh7fff_ffff;
      2: pick_value = 32'sh0000_0000;
      3: pick_value = -32'sd1;
      4: pick_value = 32'sh5555_5555;
      5: pick_value = 32'shaaaa_aaaa;
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_request(pli_pkg::MODE_DELETE, 0, 32'sh1234_5678);
    send_request(pli_pkg::MODE_INSERT, 1, 32'sh0000_0001);
    send_request(pli_pkg::MODE_INSERT, 0, 32'sh7fff_ffff);
    send_request(pli_pkg::MODE_DELETE, 0, 32'sh0000_0000);
  endtask

  task automatic test_fill_to_capacity();
    int i;
    for (i = 0; i < CAP; i++) begin
      case (i % 3)
        0: send_request(pli_pkg::MODE_INSERT, 0, pick_value(i));
        1: send_request(pli_pkg::MODE_INSERT, shadow_len, pick_value(i));
        default: send_request(pli_pkg::MODE_INSERT, shadow_len / 2, pick_value(i));
      endcase
    end
    send_request(pli_pkg::MODE_INSERT, 5, 32'sh0bad_cafe);
    send_request(pli_pkg::MODE_INSERT, CAP, 32'sh0bad_cafe);
    // range test wins over the full test
    send_request(pli_pkg::MODE_INSERT, CAP + 1, 32'sh0bad_cafe);
    send_request(pli_pkg::MODE_DELETE, CAP, 32'sh0);
  endtask

  task automatic test_delete_positions();
    send_request(pli_pkg::MODE_DELETE, shadow_len - 1, 32'sh0);
    send_request(pli_pkg::MODE_DELETE, 0, 32'shffff_ffff);
    send_request(pli_pkg::MODE_DELETE, shadow_len / 2, 32'sh0);
  endtask

  task automatic test_random_mix(input int count);
    int  n;
    int  p;
    logic m;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 12) begin
        m = ($urandom_range(0, 1) == 0) ? pli_pkg::MODE_INSERT : pli_pkg::MODE_DELETE;
        p = $urandom_range(0, CAP);
      end else begin
        if (shadow_len == 0 || (shadow_len < CAP && $urandom_range(0, CAP) >= shadow_len))
          m = pli_pkg::MODE_INSERT;
        else
          m = pli_pkg::MODE_DELETE;
        p = (m == pli_pkg::MODE_INSERT) ? $urandom_range(0, shadow_len)
                                        : $urandom_range(0, shadow_len - 1);
      end
      send_request(m, p, ($urandom_range(0, 3) == 0) ? pick_value($urandom_range(0, 5))
                                                      : $signed($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_to_capacity();
    test_delete_positions();
    test_random_mix(93);
    start <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("PASS positional_list_insert_delete_core");
    end else begin
      $display("FAIL positional_list_insert_delete_core");
    end
    $finish;
  end

endmodule
